// File: design/ulc_pkg.sv
// ----------------------------------------------------------------------------
// ulc_pkg : shared types and constants for the local calendar converter
// Holds the pipeline payload types, the calendar constants and the fixed-point
// reciprocals used for the divisions by constants other than powers of two.
// ----------------------------------------------------------------------------
package ulc_pkg;

   // calendar constants
   localparam int SECONDS_PER_DAY   = 86400;
   localparam int SEC_SHIFT         = 7;        // 86400 = 2^7 * 675
   localparam int SEC_ODD           = 675;
   localparam int DAYS_PER_ERA      = 146097;
   localparam int EPOCH_SHIFT_DAYS  = 719468;
   localparam int YEARS_PER_ERA     = 400;
   localparam int DAYS_PER_YEAR     = 365;
   localparam int DAYS_PER_WEEK     = 7;
   localparam int MINUTES_PER_HOUR  = 60;
   localparam int HOURS_HALF_DAY    = 12;
   localparam int MARCH_MONTH_SPAN  = 153;      // days in five months from March

   // Whole eras added to the day count so that every day index is positive.
   // An era is a whole number of weeks, so the weekday phase is unchanged.
   localparam int ERA_BIAS          = 128;
   localparam int YEAR_BIAS         = ERA_BIAS * YEARS_PER_ERA;
   // day index mod 7 relates to Sunday-based weekday by this shift
   localparam int WEEK_DAY_SHIFT    = 3;

   // seconds added to local time: day index then needs no further shift
   localparam logic [41:0] BIAS_SECONDS =
      42'((longint'(EPOCH_SHIFT_DAYS) + longint'(ERA_BIAS) * longint'(DAYS_PER_ERA))
          * longint'(SECONDS_PER_DAY));

   // reciprocal shifts: operand width plus divisor width
   localparam int SHR_SEC_HI  = 28;
   localparam int SHR_SEC_LO  = 37;
   localparam int SHR_ERA     = 43;
   localparam int SHR_D1460   = 29;
   localparam int SHR_D36524  = 34;
   localparam int SHR_D365    = 27;
   localparam int SHR_D100    = 16;
   localparam int SHR_D153    = 19;
   localparam int SHR_D5      = 14;
   localparam int SHR_MIN     = 23;
   localparam int SHR_HOUR    = 17;
   localparam int SHR_WEEK    = 28;

   // rounded-up reciprocals, exact for the stated operand widths
   localparam logic [18:0] RCP_SEC_HI =
      19'((64'd1 << SHR_SEC_HI) / 64'(SEC_ODD) + 64'd1);
   localparam logic [27:0] RCP_SEC_LO =
      28'((64'd1 << SHR_SEC_LO) / 64'(SEC_ODD) + 64'd1);
   localparam logic [25:0] RCP_ERA =
      26'((64'd1 << SHR_ERA) / 64'(DAYS_PER_ERA) + 64'd1);
   localparam logic [18:0] RCP_D1460 =
      19'((64'd1 << SHR_D1460) / 64'd1460 + 64'd1);
   localparam logic [18:0] RCP_D36524 =
      19'((64'd1 << SHR_D36524) / 64'd36524 + 64'd1);
   localparam logic [18:0] RCP_D365 =
      19'((64'd1 << SHR_D365) / 64'(DAYS_PER_YEAR) + 64'd1);
   localparam logic [9:0] RCP_D100 =
      10'((64'd1 << SHR_D100) / 64'd100 + 64'd1);
   localparam logic [11:0] RCP_D153 =
      12'((64'd1 << SHR_D153) / 64'(MARCH_MONTH_SPAN) + 64'd1);
   localparam logic [11:0] RCP_D5 =
      12'((64'd1 << SHR_D5) / 64'd5 + 64'd1);
   localparam logic [17:0] RCP_MIN =
      18'((64'd1 << SHR_MIN) / 64'(MINUTES_PER_HOUR) + 64'd1);
   localparam logic [11:0] RCP_HOUR =
      12'((64'd1 << SHR_HOUR) / 64'(MINUTES_PER_HOUR) + 64'd1);
   localparam logic [25:0] RCP_WEEK =
      26'((64'd1 << SHR_WEEK) / 64'(DAYS_PER_WEEK) + 64'd1);

   // biased day index and second of the day
   typedef struct packed {
      logic [24:0] day_idx;
      logic [16:0] sec_of_day;
   } split_type;

   // time-of-day part of a result
   typedef struct packed {
      logic [4:0] hour_shown;
      logic [5:0] minute_of_hour;
      logic       after_noon;
      logic [2:0] week_day;
   } clock_type;

   // complete result
   typedef struct packed {
      logic [16:0] civil_year;
      logic [3:0]  civil_month;
      logic [4:0]  day_of_month;
      clock_type   clk;
   } result_type;

endpackage

// File: design/unix_time_to_local_calendar_core.sv
// ----------------------------------------------------------------------------
// unix_time_to_local_calendar_core : Unix seconds to local date and time
// Top level: configuration registers, the conversion pipeline and the
// output register with its skid entry.
// ----------------------------------------------------------------------------
// The block takes one timestamp per clock cycle while req_tready is high and
// returns one result per timestamp, in order. The accepting edge loads the
// first of 19 pipeline stages, each but stage P at most one multiply deep,
// and the output register follows them. A result waiting at the output
// does not stop intake: a second output entry absorbs one more transaction,
// and req_tready falls only while both entries are full, which freezes the
// whole pipeline without losing or repeating anything. Zone offset and
// hour mode are read as the transaction passes the stage that needs them, so
// they are written only while the block is empty; the user must ensure this,
// as the block itself does not enforce it.
module unix_time_to_local_calendar_core (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [40:0] epoch_seconds, [47:41] zero
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [16:0] civil_year, [20:17] civil_month,
                                    // [25:21] day_of_month, [28:26] week_day,
                                    // [33:29] hour_shown, [39:34] minute_of_hour,
                                    // [40] after_noon, [47:41] zero
   // configuration writes
   input  logic        csr_wen,
   input  logic [0:0]  csr_addr,
   input  logic [11:0] csr_wdata
);

   typedef enum logic [0:0] {
      CSR_ZONE_OFFSET    = 1'b0,
      CSR_TWENTY_FOUR_HR = 1'b1
   } csr_index_type;

   // configuration registers
   logic [11:0] zone_ff;
   logic        twenty_four_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff        <= '0;
         twenty_four_ff <= 1'b1;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_addr))
            CSR_ZONE_OFFSET:    zone_ff        <= csr_wdata;
            CSR_TWENTY_FOUR_HR: twenty_four_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline
   logic                advance;
   logic                split_vld, clk_vld, pipe_vld;
   ulc_pkg::split_type  split_data;
   logic [24:0]         clk_day_idx;
   ulc_pkg::clock_type  clk_data;
   ulc_pkg::result_type pipe_data;

   ulc_split u_split (
      .clock               (clock),
      .reset               (reset),
      .advance             (advance),
      .in_valid            (req_tvalid),
      .epoch_seconds       (req_tdata[40:0]),
      .zone_offset_minutes (zone_ff),
      .out_valid           (split_vld),
      .out_data            (split_data)
   );

   ulc_clock u_clock (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .in_valid         (split_vld),
      .in_data          (split_data),
      .twenty_four_hour (twenty_four_ff),
      .out_valid        (clk_vld),
      .out_day_idx      (clk_day_idx),
      .out_clk          (clk_data)
   );

   ulc_civil u_civil (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (clk_vld),
      .in_day_idx (clk_day_idx),
      .in_clk     (clk_data),
      .out_valid  (pipe_vld),
      .out_data   (pipe_data)
   );

   // output register and skid entry
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic                skid_valid_ff, skid_valid_in;
   ulc_pkg::result_type rsp_data_ff, rsp_data_in;
   ulc_pkg::result_type skid_data_ff;
   logic                push, pop;

   assign advance    = !skid_valid_ff;
   assign req_tready = advance;
   assign push       = advance && pipe_vld;
   assign pop        = rsp_tvalid_ff && rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_tvalid_ff || pop) begin
            rsp_tvalid_in = 1'b1;
            rsp_data_in   = pipe_data;
         end else begin
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (push) begin
         skid_data_ff <= pipe_data;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'd0,
                        rsp_data_ff.clk.after_noon,
                        rsp_data_ff.clk.minute_of_hour,
                        rsp_data_ff.clk.hour_shown,
                        rsp_data_ff.clk.week_day,
                        rsp_data_ff.day_of_month,
                        rsp_data_ff.civil_month,
                        rsp_data_ff.civil_year};

   // checks
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_tvalid_ff)
      else $error("skid entry holds a transaction while the output register is empty");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (push && rsp_tvalid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("transaction from the pipeline not kept while the output stalls");

   a_result_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_data_ff.civil_month >= 4'd1 && rsp_data_ff.civil_month <= 4'd12
                         && rsp_data_ff.day_of_month != 5'd0
                         && rsp_data_ff.clk.minute_of_hour <= 6'd59
                         && rsp_data_ff.clk.week_day <= 3'd6
                         && rsp_data_ff.clk.hour_shown <= 5'd23))
      else $error("calendar field out of range");

   a_midnight_not_pm: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_data_ff.clk.hour_shown == 5'd0) |-> !rsp_data_ff.clk.after_noon)
      else $error("hour zero flagged as afternoon");

endmodule

// File: design/ulc_split.sv
// ----------------------------------------------------------------------------
// ulc_split : local time and day split
// Adds the zone offset and a positive bias, then divides by 86400 in two
// chunks of long division, giving the biased day index and second of day.
// ----------------------------------------------------------------------------
module ulc_split (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [40:0]        epoch_seconds,
   input  logic [11:0]        zone_offset_minutes,
   output logic               out_valid,
   output ulc_pkg::split_type out_data
);

   localparam int STAGES = 5;

   logic [STAGES-1:0] vld_ff;

   // stage A: local seconds plus bias, always positive
   logic [41:0] t_ext, zone_ext, zone_sec, local_in, local_ff;

   assign t_ext    = {epoch_seconds[40], epoch_seconds};
   assign zone_ext = {{30{zone_offset_minutes[11]}}, zone_offset_minutes};
   assign zone_sec = (zone_ext << 6) - (zone_ext << 2);
   assign local_in = t_ext + zone_sec + ulc_pkg::BIAS_SECONDS;

   // stage B: high chunk of (local >> 7) divided by 675
   logic [17:0] ph;
   logic [36:0] prod_hi;
   logic [8:0]  qh_in, qh_b_ff;
   logic [17:0] ph_b_ff;
   logic [16:0] pl_b_ff;
   logic [6:0]  lo_b_ff;

   assign ph      = local_ff[41:24];
   assign prod_hi = 37'(ph) * 37'(ulc_pkg::RCP_SEC_HI);
   assign qh_in   = 9'(prod_hi >> ulc_pkg::SHR_SEC_HI);

   // stage C: high chunk remainder
   logic [9:0]  rh_in, rh_c_ff;
   logic [8:0]  qh_c_ff;
   logic [16:0] pl_c_ff;
   logic [6:0]  lo_c_ff;

   assign rh_in = 10'(ph_b_ff - 18'(qh_b_ff) * 18'(ulc_pkg::SEC_ODD));

   // stage D: remainder joined with low chunk, divided by 675
   logic [26:0] x_in, x_d_ff;
   logic [54:0] prod_lo;
   logic [16:0] ql_in, ql_d_ff;
   logic [8:0]  qh_d_ff;
   logic [6:0]  lo_d_ff;

   assign x_in    = {rh_c_ff, pl_c_ff};
   assign prod_lo = 55'(x_in) * 55'(ulc_pkg::RCP_SEC_LO);
   assign ql_in   = 17'(prod_lo >> ulc_pkg::SHR_SEC_LO);

   // stage E: final remainder gives the second of the day
   logic [9:0]         r_in;
   ulc_pkg::split_type out_in, out_ff;

   assign r_in              = 10'(x_d_ff - 27'(ql_d_ff) * 27'(ulc_pkg::SEC_ODD));
   assign out_in.day_idx    = 25'({qh_d_ff, ql_d_ff});
   assign out_in.sec_of_day = {r_in, lo_d_ff};

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         local_ff <= local_in;
         qh_b_ff  <= qh_in;
         ph_b_ff  <= ph;
         pl_b_ff  <= local_ff[23:7];
         lo_b_ff  <= local_ff[6:0];
         rh_c_ff  <= rh_in;
         qh_c_ff  <= qh_b_ff;
         pl_c_ff  <= pl_b_ff;
         lo_c_ff  <= lo_b_ff;
         x_d_ff   <= x_in;
         ql_d_ff  <= ql_in;
         qh_d_ff  <= qh_c_ff;
         lo_d_ff  <= lo_c_ff;
         out_ff   <= out_in;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_data  = out_ff;

endmodule

// File: design/ulc_clock.sv
// ----------------------------------------------------------------------------
// ulc_clock : hour, minute and weekday
// Splits the second of the day into hour and minute, forms the shown hour and
// the afternoon flag, and reduces the day index modulo seven.
// ----------------------------------------------------------------------------
module ulc_clock (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  ulc_pkg::split_type in_data,
   input  logic               twenty_four_hour,
   output logic               out_valid,
   output logic [24:0]        out_day_idx,
   output ulc_pkg::clock_type out_clk
);

   localparam int STAGES = 3;

   logic [STAGES-1:0] vld_ff;

   // stage F: minute of day, week quotient
   logic [34:0] prod_min;
   logic [10:0] mins_in, mins_f_ff;
   logic [24:0] w_in, w_f_ff, day_f_ff;
   logic [50:0] prod_week;
   logic [22:0] q7_in, q7_f_ff;

   assign prod_min  = 35'(in_data.sec_of_day) * 35'(ulc_pkg::RCP_MIN);
   assign mins_in   = 11'(prod_min >> ulc_pkg::SHR_MIN);
   assign w_in      = in_data.day_idx + 25'(ulc_pkg::WEEK_DAY_SHIFT);
   assign prod_week = 51'(w_in) * 51'(ulc_pkg::RCP_WEEK);
   assign q7_in     = 23'(prod_week >> ulc_pkg::SHR_WEEK);

   // stage G: hour and weekday
   logic [22:0] prod_hour;
   logic [4:0]  hour_in, hour_g_ff;
   logic [2:0]  wd_in, wd_g_ff;
   logic [10:0] mins_g_ff;
   logic [24:0] day_g_ff;

   assign prod_hour = 23'(mins_f_ff) * 23'(ulc_pkg::RCP_HOUR);
   assign hour_in   = 5'(prod_hour >> ulc_pkg::SHR_HOUR);
   assign wd_in     = 3'(w_f_ff - 25'(q7_f_ff) * 25'(ulc_pkg::DAYS_PER_WEEK));

   // stage H: minute and shown hour; midnight and noon show as 12 in 12-hour mode
   logic [4:0]         h12;
   ulc_pkg::clock_type clk_in, clk_ff;
   logic [24:0]        day_h_ff;

   always_comb begin
      clk_in.after_noon     = (hour_g_ff >= 5'(ulc_pkg::HOURS_HALF_DAY));
      clk_in.minute_of_hour = 6'(mins_g_ff - 11'(hour_g_ff) * 11'(ulc_pkg::MINUTES_PER_HOUR));
      clk_in.week_day       = wd_g_ff;
      h12 = clk_in.after_noon ? hour_g_ff - 5'(ulc_pkg::HOURS_HALF_DAY) : hour_g_ff;
      if (twenty_four_hour) begin
         clk_in.hour_shown = hour_g_ff;
      end else if (h12 == 5'd0) begin
         clk_in.hour_shown = 5'(ulc_pkg::HOURS_HALF_DAY);
      end else begin
         clk_in.hour_shown = h12;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         mins_f_ff <= mins_in;
         w_f_ff    <= w_in;
         q7_f_ff   <= q7_in;
         day_f_ff  <= in_data.day_idx;
         hour_g_ff <= hour_in;
         wd_g_ff   <= wd_in;
         mins_g_ff <= mins_f_ff;
         day_g_ff  <= day_f_ff;
         clk_ff    <= clk_in;
         day_h_ff  <= day_g_ff;
      end
   end

   assign out_valid   = vld_ff[STAGES-1];
   assign out_day_idx = day_h_ff;
   assign out_clk     = clk_ff;

endmodule

// File: design/ulc_civil.sv
// ----------------------------------------------------------------------------
// ulc_civil : day index to proleptic Gregorian date
// Era, day of era, year of era, day of year and March-based month; each stage
// but P is at most one multiply deep. The time-of-day part rides alongside.
// ----------------------------------------------------------------------------
module ulc_civil (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [24:0]         in_day_idx,
   input  ulc_pkg::clock_type  in_clk,
   output logic                out_valid,
   output ulc_pkg::result_type out_data
);

   localparam int STAGES = 11;

   logic [STAGES-1:0]  vld_ff;
   // time-of-day delay line; the last stage uses the output register
   ulc_pkg::clock_type clk_ff [STAGES-1];

   // stage I: era
   logic [50:0] prod_era;
   logic [7:0]  era_in, era_i_ff;
   logic [24:0] day_i_ff;

   assign prod_era = 51'(in_day_idx) * 51'(ulc_pkg::RCP_ERA);
   assign era_in   = 8'(prod_era >> ulc_pkg::SHR_ERA);

   // stage J: day of era, year base with the era bias removed
   logic [17:0] doe_in, doe_j_ff;
   logic [16:0] yrb_in, yrb_j_ff;

   assign doe_in = 18'(day_i_ff - 25'(era_i_ff) * 25'(ulc_pkg::DAYS_PER_ERA));
   assign yrb_in = 17'(era_i_ff) * 17'(ulc_pkg::YEARS_PER_ERA) - 17'(ulc_pkg::YEAR_BIAS);

   // stage K: leap corrections doe/1460 and doe/36524
   logic [36:0] prod_1460, prod_36524;
   logic [6:0]  n1460_in, n1460_k_ff;
   logic [2:0]  n36524_in, n36524_k_ff;
   logic [17:0] doe_k_ff;
   logic [16:0] yrb_k_ff;

   assign prod_1460  = 37'(doe_j_ff) * 37'(ulc_pkg::RCP_D1460);
   assign n1460_in   = 7'(prod_1460 >> ulc_pkg::SHR_D1460);
   assign prod_36524 = 37'(doe_j_ff) * 37'(ulc_pkg::RCP_D36524);
   assign n36524_in  = 3'(prod_36524 >> ulc_pkg::SHR_D36524);

   // stage L: corrected day count; last day of an era counts once more
   logic        era_end;
   logic [17:0] val_in, val_l_ff, doe_l_ff;
   logic [16:0] yrb_l_ff;

   assign era_end = (doe_k_ff == 18'(ulc_pkg::DAYS_PER_ERA - 1));
   assign val_in  = doe_k_ff - 18'(n1460_k_ff) + 18'(n36524_k_ff) - 18'(era_end);

   // stage M: year of era
   logic [36:0] prod_365;
   logic [8:0]  yoe_in, yoe_m_ff;
   logic [17:0] doe_m_ff;
   logic [16:0] yrb_m_ff;

   assign prod_365 = 37'(val_l_ff) * 37'(ulc_pkg::RCP_D365);
   assign yoe_in   = 9'(prod_365 >> ulc_pkg::SHR_D365);

   // stage N: century count and year length in days
   logic [18:0] prod_100;
   logic [1:0]  c100_in, c100_n_ff;
   logic [17:0] y365_in, y365_n_ff, doe_n_ff;
   logic [8:0]  yoe_n_ff;
   logic [16:0] yrb_n_ff;

   assign prod_100 = 19'(yoe_m_ff) * 19'(ulc_pkg::RCP_D100);
   assign c100_in  = 2'(prod_100 >> ulc_pkg::SHR_D100);
   assign y365_in  = 18'(yoe_m_ff) * 18'(ulc_pkg::DAYS_PER_YEAR);

   // stage O: day of year (March based), year before month carry
   logic [8:0]  doy_in, doy_o_ff;
   logic [16:0] yrp_in, yrp_o_ff;

   assign doy_in = 9'(doe_n_ff - (y365_n_ff + 18'(yoe_n_ff >> 2) - 18'(c100_n_ff)));
   assign yrp_in = yrb_n_ff + 17'(yoe_n_ff);

   // stage P: March-based month
   logic [10:0] mp_arg;
   logic [22:0] prod_153;
   logic [3:0]  mp_in, mp_p_ff;
   logic [8:0]  doy_p_ff;
   logic [16:0] yrp_p_ff;

   assign mp_arg   = 11'(doy_o_ff) * 11'd5 + 11'd2;
   assign prod_153 = 23'(mp_arg) * 23'(ulc_pkg::RCP_D153);
   assign mp_in    = 4'(prod_153 >> ulc_pkg::SHR_D153);

   // stage Q: month span numerator
   logic [10:0] a153_in, a153_q_ff;
   logic [3:0]  mp_q_ff;
   logic [8:0]  doy_q_ff;
   logic [16:0] yrp_q_ff;

   assign a153_in = 11'(mp_p_ff) * 11'(ulc_pkg::MARCH_MONTH_SPAN) + 11'd2;

   // stage R: days before the month
   logic [22:0] prod_5;
   logic [8:0]  dd_in, dd_r_ff, doy_r_ff;
   logic [3:0]  mp_r_ff;
   logic [16:0] yrp_r_ff;

   assign prod_5 = 23'(a153_q_ff) * 23'(ulc_pkg::RCP_D5);
   assign dd_in  = 9'(prod_5 >> ulc_pkg::SHR_D5);

   // stage S: day, calendar month; January and February belong to next year
   logic                jan_feb;
   ulc_pkg::result_type out_in, out_ff;

   assign jan_feb = (mp_r_ff >= 4'd10);

   always_comb begin
      out_in.day_of_month = 5'(doy_r_ff - dd_r_ff + 9'd1);
      out_in.civil_month  = jan_feb ? mp_r_ff - 4'd9 : mp_r_ff + 4'd3;
      out_in.civil_year   = yrp_r_ff + 17'(jan_feb);
      out_in.clk          = clk_ff[STAGES-2];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         clk_ff[0] <= in_clk;
         for (int i = 1; i < STAGES - 1; i++) begin
            clk_ff[i] <= clk_ff[i-1];
         end
         era_i_ff    <= era_in;
         day_i_ff    <= in_day_idx;
         doe_j_ff    <= doe_in;
         yrb_j_ff    <= yrb_in;
         n1460_k_ff  <= n1460_in;
         n36524_k_ff <= n36524_in;
         doe_k_ff    <= doe_j_ff;
         yrb_k_ff    <= yrb_j_ff;
         val_l_ff    <= val_in;
         doe_l_ff    <= doe_k_ff;
         yrb_l_ff    <= yrb_k_ff;
         yoe_m_ff    <= yoe_in;
         doe_m_ff    <= doe_l_ff;
         yrb_m_ff    <= yrb_l_ff;
         c100_n_ff   <= c100_in;
         y365_n_ff   <= y365_in;
         yoe_n_ff    <= yoe_m_ff;
         doe_n_ff    <= doe_m_ff;
         yrb_n_ff    <= yrb_m_ff;
         doy_o_ff    <= doy_in;
         yrp_o_ff    <= yrp_in;
         mp_p_ff     <= mp_in;
         doy_p_ff    <= doy_o_ff;
         yrp_p_ff    <= yrp_o_ff;
         a153_q_ff   <= a153_in;
         mp_q_ff     <= mp_p_ff;
         doy_q_ff    <= doy_p_ff;
         yrp_q_ff    <= yrp_p_ff;
         dd_r_ff     <= dd_in;
         mp_r_ff     <= mp_q_ff;
         doy_r_ff    <= doy_q_ff;
         yrp_r_ff    <= yrp_q_ff;
         out_ff      <= out_in;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_data  = out_ff;

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb : self-checking bench for unix_time_to_local_calendar_core
// Drives signed Unix timestamps through the stream input under several zone
// offsets and both hour modes. An internal calendar predictor produces the
// expected local date and time for each accepted transaction, and every
// result transaction is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;

   // register indexes of the configuration port
   localparam logic [0:0] REG_ZONE_OFFSET = 1'b0;
   localparam logic [0:0] REG_HOUR_MODE   = 1'b1;

   // calendar constants for the predictor
   localparam longint SECS_PER_DAY   = 86400;
   localparam longint SECS_PER_HOUR  = 3600;
   localparam longint DAYS_PER_ERA   = 146097;
   localparam longint MARCH_EPOCH    = 719468;
   localparam longint TS_MAX         = 64'sd1099511627775;
   localparam longint TS_MIN         = -64'sd1099511627776;

   localparam int     PIPE_LATENCY   = 20;
   localparam int     ITEMS_PER_RUN  = 75;

   // one expected or observed calendar result
   typedef struct packed {
      logic [16:0] civil_year;
      logic [3:0]  civil_month;
      logic [4:0]  day_of_month;
      logic [2:0]  week_day;
      logic [4:0]  hour_shown;
      logic [5:0]  minute_of_hour;
      logic        after_noon;
   } calendar_type;

   // -------------------------------------------------------------------------
   // calendar scoreboard: predicts local date/time and checks results in order
   // -------------------------------------------------------------------------
   class calendar_board;
      logic signed [11:0] zone_minutes = 12'sd0;
      logic               clock24      = 1'b1;
      calendar_type       due_q[$];
      int                 errors       = 0;
      int                 checked      = 0;

      function automatic calendar_type local_calendar(logic signed [40:0] ts);
         calendar_type res;
         longint    loc, day_num, sec_of_day, shifted, era_idx, day_of_era;
         longint    year_of_era, day_of_year, march_month, mday, mon, year, wday;
         longint    hour24, hour12;
         loc = longint'(ts) + longint'(zone_minutes) * 60;
         day_num    = loc / SECS_PER_DAY;
         sec_of_day = loc % SECS_PER_DAY;
         // floor towards minus infinity
         if (sec_of_day < 0) begin
            sec_of_day = sec_of_day + SECS_PER_DAY;
            day_num    = day_num - 1;
         end
         // era split, years counted from 1 March
         shifted = day_num + MARCH_EPOCH;
         if (shifted >= 0)
            era_idx = shifted / DAYS_PER_ERA;
         else
            era_idx = (shifted - (DAYS_PER_ERA - 1)) / DAYS_PER_ERA;
         day_of_era  = shifted - era_idx * DAYS_PER_ERA;
         year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                        - day_of_era / 146096) / 365;
         day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4
                                     - year_of_era / 100);
         march_month = (5 * day_of_year + 2) / 153;
         mday = day_of_year - (153 * march_month + 2) / 5 + 1;
         if (march_month < 10)
            mon = march_month + 3;
         else
            mon = march_month - 9;
         year = year_of_era + era_idx * 400;
         if (mon <= 2)
            year = year + 1;
         // 1970-01-01 was a Thursday
         wday = (day_num + 4) % 7;
         if (wday < 0)
            wday = wday + 7;
         hour24 = sec_of_day / SECS_PER_HOUR;
         hour12 = hour24 % 12;
         if (hour12 == 0)
            hour12 = 12;
         res.civil_year     = 17'(year);
         res.civil_month    = 4'(mon);
         res.day_of_month   = 5'(mday);
         res.week_day       = 3'(wday);
         res.hour_shown     = clock24 ? 5'(hour24) : 5'(hour12);
         res.minute_of_hour = 6'((sec_of_day / 60) % 60);
         res.after_noon     = (hour24 >= 12);
         return res;
      endfunction

      function void note_timestamp(logic signed [40:0] ts);
         due_q.push_back(local_calendar(ts));
      endfunction

      function int pending();
         return due_q.size();
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("ERROR result %0d: %s", checked, what);
      endtask

      task compare_field(string name, longint unsigned got, longint unsigned want);
         if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
      endtask

      task check_result(logic [47:0] data);
         calendar_type got, want;
         got.civil_year     = data[16:0];
         got.civil_month    = data[20:17];
         got.day_of_month   = data[25:21];
         got.week_day       = data[28:26];
         got.hour_shown     = data[33:29];
         got.minute_of_hour = data[39:34];
         got.after_noon     = data[40];
         if (due_q.size() == 0) begin
            report_mismatch("result with nothing outstanding");
         end else begin
            want = due_q.pop_front();
            compare_field("civil_year", got.civil_year, want.civil_year);
            compare_field("civil_month", got.civil_month, want.civil_month);
            compare_field("day_of_month", got.day_of_month, want.day_of_month);
            compare_field("week_day", got.week_day, want.week_day);
            compare_field("hour_shown", got.hour_shown, want.hour_shown);
            compare_field("minute_of_hour", got.minute_of_hour, want.minute_of_hour);
            compare_field("after_noon", got.after_noon, want.after_noon);
            compare_field("pad", data[47:41], 0);
         end
         checked++;
      endtask
   endclass

   // -------------------------------------------------------------------------
   // signals and DUT
   // -------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [47:0] rsp_tdata;
   logic        csr_wen    = 1'b0;
   logic [0:0]  csr_addr   = REG_ZONE_OFFSET;
   logic [11:0] csr_wdata  = '0;

   bit            calm = 1'b0;   // no idling on either side when set
   calendar_board book = new();

   unix_time_to_local_calendar_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         book.check_result(rsp_tdata);
   end

   // result side back-pressure in random bursts
   initial begin : rsp_pacing
      int unsigned n;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 7);
            rsp_tready <= 1'b0;
         end else begin
            n = $urandom_range(1, 12);
            rsp_tready <= 1'b1;
         end
         repeat (n) @(posedge clock);
      end
   end

   // watchdog
   initial begin
      #2000000;
      $display("unix_time_to_local_calendar_core: mismatch");
      $finish;
   end

   // -------------------------------------------------------------------------
   // stimulus tasks
   // -------------------------------------------------------------------------

   // one timestamp transaction, optionally preceded by an idle burst
   task automatic send_timestamp(input longint value);
      int unsigned        gap;
      logic signed [40:0] ts;
      ts = 41'(value);
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, ts};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_timestamp(ts);
   endtask

   // stop sending and wait for every outstanding result
   task automatic hold_until_empty();
      req_tvalid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // write both registers while the pipeline is empty
   task automatic apply_settings(input logic signed [11:0] zone, input logic mode);
      csr_wen   <= 1'b1;
      csr_addr  <= REG_ZONE_OFFSET;
      csr_wdata <= zone;
      @(posedge clock);
      csr_addr  <= REG_HOUR_MODE;
      csr_wdata <= {11'd0, mode};
      @(posedge clock);
      csr_wen   <= 1'b0;
      book.zone_minutes = zone;
      book.clock24      = mode;
   endtask

   // random timestamp: full range, near epoch, day/hour edges, eras, extremes
   function automatic longint random_timestamp();
      longint k, v;
      case ($urandom_range(0, 5))
         0: v = longint'({$urandom, $urandom});
         1: v = longint'($urandom) - 64'sd2147483648;
         2: begin
            k = longint'($urandom_range(0, 25000000)) - 12500000;
            v = k * SECS_PER_DAY - longint'(book.zone_minutes) * 60
                + longint'($urandom_range(0, 6)) - 3;
         end
         3: begin
            k = longint'($urandom_range(0, 2000000)) - 1000000;
            v = k * SECS_PER_HOUR + longint'($urandom_range(0, 2)) - 1;
         end
         4: begin
            k = $urandom_range(0, 4000);
            v = $urandom_range(0, 1) ? TS_MAX - k : TS_MIN + k;
         end
         default: begin
            k = longint'($urandom_range(0, 160)) - 80;
            v = (k * DAYS_PER_ERA - MARCH_EPOCH + longint'($urandom_range(0, 4)) - 2)
                * SECS_PER_DAY + longint'($urandom_range(0, 86399));
         end
      endcase
      return v;
   endfunction

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin : main
      logic signed [11:0] zone_set [8];
      logic               mode_set [8];
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: UTC, 24-hour; extremes and calendar edges
      send_timestamp(0);
      send_timestamp(-1);
      send_timestamp(TS_MAX);
      send_timestamp(TS_MIN);
      send_timestamp(86399);
      send_timestamp(86400);
      send_timestamp(-86400);
      send_timestamp(-86401);
      send_timestamp(951782400);      // 2000-02-29
      send_timestamp(951868800);      // 2000-03-01
      send_timestamp(-2208988800);    // 1900-01-01
      send_timestamp(253402300799);   // 9999-12-31 23:59:59
      hold_until_empty();

      // 12-hour mode: midnight, noon and neighbours
      apply_settings(12'sd0, 1'b0);
      send_timestamp(0);
      send_timestamp(43199);
      send_timestamp(43200);
      send_timestamp(46800);
      send_timestamp(3600);
      send_timestamp(86399);
      hold_until_empty();

      // offsets beyond one day at both ends of the register range
      apply_settings(-12'sd2048, 1'b1);
      send_timestamp(0);
      send_timestamp(TS_MIN);
      send_timestamp(TS_MAX);
      hold_until_empty();
      apply_settings(12'sd2047, 1'b0);
      send_timestamp(0);
      send_timestamp(TS_MAX);
      send_timestamp(TS_MIN);
      hold_until_empty();

      // random runs over a spread of settings, the last without idling
      zone_set = '{12'sd0, -12'sd1440, 12'sd1440, -12'sd2048, 12'sd2047,
                   12'sd60, -12'sd330, 12'sd0};
      mode_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
      zone_set[5] = 12'($urandom_range(0, 4095));
      zone_set[7] = 12'($urandom_range(0, 4095));
      mode_set[7] = 1'($urandom_range(0, 1));
      for (int p = 0; p < 8; p++) begin
         calm = (p == 7);
         apply_settings(zone_set[p], mode_set[p]);
         for (int i = 0; i < ITEMS_PER_RUN; i++) begin
            // one mid-stream pause until the pipeline has emptied
            if (p == 2 && i == 37)
               hold_until_empty();
            send_timestamp(random_timestamp());
         end
         hold_until_empty();
      end

      repeat (PIPE_LATENCY + 5) @(posedge clock);
      if (book.errors == 0 && book.pending() == 0)
         $display("unix_time_to_local_calendar_core: match");
      else
         $display("unix_time_to_local_calendar_core: mismatch");
      $finish;
   end

endmodule
